// File: sv/sidt_pkg.sv
package sidt_pkg;

  localparam int unsigned DIGIT_W = 4;
  localparam int unsigned CHAR_W = 8;

  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;
  localparam logic [CHAR_W-1:0] CHAR_NINE  = 8'h39;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CONV,
    ST_SKIP,
    ST_SIGN,
    ST_EMIT
  } state_e;

endpackage

// File: sv/signed_integer_to_decimal_text_unit.sv
// Signed binary to decimal ASCII converter.
// Input channel (in_valid_i / in_ready_o) carries one two's-complement value_i per
// transaction. The output channel (out_valid_o / out_ready_i) returns that number's
// decimal text one character per transaction, most significant first: a leading
// '-' for negative values, no leading zeros, a single '0' for zero. last_o marks
// the final character of each number.
// Conversion for VALUE_WIDTH bits, with ND = floor(VALUE_WIDTH * log10(2)) + 1 BCD digits
// (10 for 32 bits): after the accepting cycle the magnitude enters a double-dabble
// shift register one bit per cycle. Leading zero digits are then dropped one per
// cycle, keeping at least one digit, and then the minus sign, if any, and the digits
// are emitted. The unit takes no new value while it converts or emits a number;
// conversion is bit-serial and the output carries one character per transaction.
// The next value is accepted while the last character still waits in the output
// register. When the receiver stalls, the unit holds its state and the pending
// character until it is taken. Reset empties the output register and returns
// the unit to idle; no item is in flight after reset.
module signed_integer_to_decimal_text_unit
  import sidt_pkg::*;
#(
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic signed [VALUE_WIDTH-1:0] value_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [CHAR_W-1:0]             character_o,
  output logic                          last_o
);

  // Decimal digits needed for 2^(VALUE_WIDTH-1): floor(W * log10(2)) + 1 bounds it.
  localparam int unsigned ND  = (VALUE_WIDTH * 30103) / 100000 + 1;
  localparam int unsigned BW  = ND * DIGIT_W;
  localparam int unsigned CW  = $clog2(VALUE_WIDTH + 1);
  localparam int unsigned DCW = $clog2(ND + 1);

  state_e                 state_q, state_d;
  logic [VALUE_WIDTH-1:0] mag_q, mag_d;
  logic [BW-1:0]          bcd_q, bcd_d;
  logic [CW-1:0]          cnt_q, cnt_d;
  logic [DCW-1:0]         dcnt_q, dcnt_d;
  logic                   neg_q, neg_d;

  logic                   out_valid_q;
  logic [CHAR_W-1:0]      char_q;
  logic                   last_q;

  logic                   slot_free;
  logic                   load;
  logic [CHAR_W-1:0]      load_char;
  logic                   load_last;
  logic [BW-1:0]          bcd_adj;
  logic [DIGIT_W-1:0]     top_digit;
  logic [VALUE_WIDTH-1:0] raw;

  assign slot_free = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == ST_IDLE);
  assign top_digit = bcd_q[BW-1 -: DIGIT_W];
  assign raw = value_i;

  // Add-3 correction on every BCD digit before each shift.
  always_comb begin
    logic [DIGIT_W-1:0] dig;
    dig = '0;
    for (int i = 0; i < ND; i++) begin
      dig = bcd_q[i*DIGIT_W +: DIGIT_W];
      bcd_adj[i*DIGIT_W +: DIGIT_W] = (dig >= 4'd5) ? dig + 4'd3 : dig;
    end
  end

  always_comb begin
    state_d   = state_q;
    mag_d     = mag_q;
    bcd_d     = bcd_q;
    cnt_d     = cnt_q;
    dcnt_d    = dcnt_q;
    neg_d     = neg_q;
    load      = 1'b0;
    load_char = CHAR_ZERO + {4'b0000, top_digit};
    load_last = (dcnt_q == DCW'(1));
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          neg_d   = raw[VALUE_WIDTH-1];
          mag_d   = raw[VALUE_WIDTH-1] ? (~raw + 1'b1) : raw;
          bcd_d   = '0;
          cnt_d   = CW'(VALUE_WIDTH);
          dcnt_d  = DCW'(ND);
          state_d = ST_CONV;
        end
      end
      ST_CONV: begin
        bcd_d = {bcd_adj[BW-2:0], mag_q[VALUE_WIDTH-1]};
        mag_d = {mag_q[VALUE_WIDTH-2:0], 1'b0};
        cnt_d = cnt_q - 1'b1;
        if (cnt_q == CW'(1)) begin
          state_d = ST_SKIP;
        end
      end
      ST_SKIP: begin
        if (top_digit == '0 && dcnt_q != DCW'(1)) begin
          bcd_d  = {bcd_q[BW-DIGIT_W-1:0], {DIGIT_W{1'b0}}};
          dcnt_d = dcnt_q - 1'b1;
        end else begin
          state_d = neg_q ? ST_SIGN : ST_EMIT;
        end
      end
      ST_SIGN: begin
        load_char = CHAR_MINUS;
        load_last = 1'b0;
        if (slot_free) begin
          load    = 1'b1;
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (slot_free) begin
          load   = 1'b1;
          bcd_d  = {bcd_q[BW-DIGIT_W-1:0], {DIGIT_W{1'b0}}};
          dcnt_d = dcnt_q - 1'b1;
          if (dcnt_q == DCW'(1)) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    mag_q  <= mag_d;
    bcd_q  <= bcd_d;
    cnt_q  <= cnt_d;
    dcnt_q <= dcnt_d;
    neg_q  <= neg_d;
    if (load) begin
      char_q <= load_char;
      last_q <= load_last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign character_o = char_q;
  assign last_o      = last_q;

`ifndef NO_ASSERTIONS
  a_char_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (character_o == CHAR_MINUS) ||
                    (character_o >= CHAR_ZERO && character_o <= CHAR_NINE))
    else $error("output character is not a digit or minus sign");

  a_sign_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && character_o == CHAR_MINUS) |-> !last_o)
    else $error("minus sign marked as final character");

  a_accept_starts_conv: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (state_q == ST_CONV))
    else $error("accepted value did not start conversion");

  a_no_load_in_conv: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CONV || state_q == ST_SKIP) |-> !load)
    else $error("character produced before conversion finished");
`endif

endmodule

// File: tb/sv/signed_integer_to_decimal_text_unit_test.sv
`timescale 1ns / 100ps

module signed_integer_to_decimal_text_unit_test;
  import sidt_pkg::*;

  localparam int unsigned VALUE_WIDTH = 32;
  localparam int unsigned MAX_DIGITS = 24;
  localparam int unsigned RANDOM_ITEMS = 100;
  localparam int unsigned DRAIN_CYCLES = 80;
  localparam int unsigned CYCLE_LIMIT = 400000;

  typedef struct packed {
    logic [CHAR_W-1:0] code;
    logic              last;
  } text_char_t;

  typedef enum logic [1:0] {
    READY_ALWAYS,
    READY_COIN,
    READY_SPARSE,
    READY_PERIODIC
  } ready_mode_e;

  logic                          clk_i = 1'b0;
  logic                          rst_ni = 1'b0;
  logic                          in_valid_i = 1'b0;
  logic                          in_ready_o;
  logic signed [VALUE_WIDTH-1:0] value_i = '0;
  logic                          out_valid_o;
  logic                          out_ready_i = 1'b0;
  logic [CHAR_W-1:0]             character_o;
  logic                          last_o;

  logic signed [VALUE_WIDTH-1:0] pending_values[$];
  text_char_t                    expected_text[$];
  int unsigned                   mismatch_count = 0;
  int unsigned                   cycle_count = 0;
  int unsigned                   burst_left = 0;
  int unsigned                   gap_left = 0;
  int unsigned                   ready_phase_left = 0;
  ready_mode_e                   ready_mode = READY_ALWAYS;

  signed_integer_to_decimal_text_unit #(
    .VALUE_WIDTH(VALUE_WIDTH)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .value_i    (value_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .character_o(character_o),
    .last_o     (last_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Appends the decimal text of one accepted value to the expected characters.
  function automatic void append_decimal_text(logic [VALUE_WIDTH-1:0] raw);
    logic [VALUE_WIDTH-1:0] magnitude;
    logic [3:0]             digit_stack[MAX_DIGITS];
    int                     digit_count;
    int                     k;
    text_char_t             entry;
    // Taking the magnitude as unsigned keeps the most negative value exact.
    magnitude = raw[VALUE_WIDTH-1] ? (~raw + 1'b1) : raw;
    digit_count = 0;
    do begin
      digit_stack[digit_count] = 4'(magnitude % 10);
      digit_count++;
      magnitude = magnitude / 10;
    end while (magnitude != 0);
    if (raw[VALUE_WIDTH-1]) begin
      entry.code = CHAR_MINUS;
      entry.last = 1'b0;
      expected_text.push_back(entry);
    end
    for (k = digit_count - 1; k >= 0; k--) begin
      entry.code = CHAR_ZERO + {4'd0, digit_stack[k]};
      entry.last = (k == 0);
      expected_text.push_back(entry);
    end
  endfunction

  function automatic logic signed [VALUE_WIDTH-1:0] random_value();
    logic signed [VALUE_WIDTH-1:0] v;
    logic signed [VALUE_WIDTH-1:0] power;
    case ($urandom_range(0, 3))
      0: v = $urandom;
      1: v = $urandom & ((32'd1 << $urandom_range(1, 31)) - 1);
      2: v = $urandom_range(0, 20) - 10;
      default: begin
        // Values around a power of ten exercise digit count changes.
        power = 1;
        repeat ($urandom_range(0, 9)) power = power * 10;
        v = power + $urandom_range(0, 2) - 1;
      end
    endcase
    if ($urandom_range(0, 1) == 1) begin
      v = -v;
    end
    return v;
  endfunction

  function automatic int unsigned random_gap();
    case ($urandom_range(0, 3))
      0: return 0;
      1: return $urandom_range(1, 2);
      2: return $urandom_range(1, 8);
      default: return $urandom_range(10, 40);
    endcase
  endfunction

  always @(posedge clk_i) begin : drive_values
    bit accepted;
    if (rst_ni) begin
      accepted = in_valid_i && in_ready_o;
      if (accepted) begin
        append_decimal_text(value_i);
        void'(pending_values.pop_front());
      end
      if (in_valid_i && !accepted) begin
        // Hold the transaction until the unit takes it.
      end else if (gap_left != 0) begin
        gap_left--;
        in_valid_i <= 1'b0;
        value_i <= $urandom;
      end else if (pending_values.size() != 0) begin
        in_valid_i <= 1'b1;
        value_i <= pending_values[0];
        if (burst_left <= 1) begin
          burst_left = $urandom_range(1, 12);
          gap_left = random_gap();
        end else begin
          burst_left--;
        end
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin : drive_ready
    if (ready_phase_left == 0) begin
      ready_mode = ready_mode_e'($urandom_range(0, 3));
      ready_phase_left = $urandom_range(20, 200);
    end else begin
      ready_phase_left--;
    end
    case (ready_mode)
      READY_ALWAYS:   out_ready_i <= 1'b1;
      READY_COIN:     out_ready_i <= ($urandom_range(0, 1) == 1);
      READY_SPARSE:   out_ready_i <= ($urandom_range(0, 3) == 0);
      default:        out_ready_i <= ((cycle_count % 7) < 3);
    endcase
  end

  always @(posedge clk_i) begin : check_text
    text_char_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_text.size() == 0) begin
        $error("character: expected none, got %h", character_o);
        mismatch_count++;
      end else begin
        want = expected_text.pop_front();
        if (character_o !== want.code) begin
          $error("character: expected %h, got %h", want.code, character_o);
          mismatch_count++;
        end
        if (last_o !== want.last) begin
          $error("last: expected %b, got %b", want.last, last_o);
          mismatch_count++;
        end
      end
    end
  end

  always @(posedge clk_i) begin : watchdog
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("signed_integer_to_decimal_text_unit_test: errors");
      $finish;
    end
  end

  initial begin
    // Directed values: zero, sign boundaries, digit count edges, alternating bits.
    pending_values.push_back(0);
    pending_values.push_back(1);
    pending_values.push_back(-1);
    pending_values.push_back(9);
    pending_values.push_back(10);
    pending_values.push_back(-10);
    pending_values.push_back(99);
    pending_values.push_back(100);
    pending_values.push_back(-7);
    pending_values.push_back(12);
    pending_values.push_back(32'sh7FFF_FFFF);
    pending_values.push_back(32'sh8000_0000);
    pending_values.push_back(32'sh8000_0001);
    pending_values.push_back(1000000000);
    pending_values.push_back(999999999);
    pending_values.push_back(-999999999);
    pending_values.push_back(-1000000000);
    pending_values.push_back(1234567890);
    pending_values.push_back(32'sh5555_5555);
    pending_values.push_back(32'shAAAA_AAAA);
    repeat (RANDOM_ITEMS) pending_values.push_back(random_value());

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (pending_values.size() != 0 || in_valid_i || expected_text.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (mismatch_count == 0) begin
      $display("signed_integer_to_decimal_text_unit_test: clean");
    end else begin
      $display("signed_integer_to_decimal_text_unit_test: errors");
    end
    $finish;
  end

endmodule
